// ===== rtl/core/nct_pkg.sv =====
// ----------------------------------------------------------------------------
// nct_pkg: shared types and constants for the neighbor cache table
// Operation and status codes, reachability states, and the command and
// status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam int ENTRY_COUNT = 16;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  typedef enum logic [2:0] {
    OP_LOOKUP     = 3'd0,
    OP_ADD        = 3'd1,
    OP_ADD_MAC    = 3'd2,
    OP_ADD_ROUTER = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_INVAL_IF   = 3'd5,
    OP_INVAL_ALL  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUP       = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam logic [2:0] REACH_INCOMPLETE = 3'd0;
  localparam logic [2:0] REACH_STALE      = 3'd2;
  localparam logic [2:0] REACH_PROBE      = 3'd4;

  // flag bits of a slot
  localparam int FLAG_ROUTER = 0;
  localparam int FLAG_HOME   = 1;
  localparam int FLAG_RING   = 2;

  typedef enum logic [1:0] {
    CAP_NONE  = 2'd0,
    CAP_FOUND = 2'd1,
    CAP_NEW   = 2'd2
  } cap_e;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    clear_all;
    logic    write_new;
    logic    read_tail;
    logic    link;
    logic    unlink;
    logic    capture;
    cap_e    cap;
    status_e status;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       found;
    logic       free_ok;
    logic       head_ok;
    logic       scan_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/nct_dp.sv =====
// ----------------------------------------------------------------------------
// nct_dp: neighbor cache table datapath
// Slot storage, default-router ring pointers, the scan pointer, the
// result staging registers and the output register.
// ----------------------------------------------------------------------------
module nct_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nct_pkg::cmd_t         cmd_i,
  output nct_pkg::dp_stat_t     stat_o,
  input  logic [2:0]            op_i,
  input  logic [63:0]           addr_high_i,
  input  logic [63:0]           addr_low_i,
  input  logic [7:0]            interface_num_i,
  input  logic [47:0]           link_address_i,
  input  logic [31:0]           expiry_ticks_i,
  input  logic                  home_agent_i,
  output logic [1:0]            status_o,
  output logic                  hit_o,
  output logic [3:0]            entry_index_o,
  output logic [47:0]           mac_out_o,
  output logic [2:0]            reach_state_o,
  output logic                  router_flag_o,
  output logic                  home_agent_flag_o,
  output logic                  default_router_flag_o,
  output logic [31:0]           expiry_out_o,
  output logic                  ring_head_valid_o,
  output logic [3:0]            ring_head_index_o
);
  import nct_pkg::*;

  // slot storage
  logic             valid_q  [ENTRY_COUNT];
  logic [63:0]      khi_q    [ENTRY_COUNT];
  logic [63:0]      klo_q    [ENTRY_COUNT];
  logic [7:0]       ifn_q    [ENTRY_COUNT];
  logic [47:0]      mac_q    [ENTRY_COUNT];
  logic [2:0]       reach_q  [ENTRY_COUNT];
  logic [2:0]       flags_q  [ENTRY_COUNT];
  logic [31:0]      exp_q    [ENTRY_COUNT];
  logic [IDX_W-1:0] next_q   [ENTRY_COUNT];
  logic [IDX_W-1:0] prev_q   [ENTRY_COUNT];
  logic             head_ok_q;
  logic [IDX_W-1:0] head_q;

  // latched transaction
  logic [2:0]  op_q;
  logic [63:0] ahi_q, alo_q;
  logic [7:0]  aif_q;
  logic [47:0] amac_q;
  logic [31:0] aexp_q;
  logic        aha_q;

  // search state
  logic [IDX_W-1:0] ptr_q, fidx_q, free_q, tail_q;
  logic             found_q, free_ok_q;

  // result staging
  status_e     r_status_q;
  logic        r_hit_q;
  logic [3:0]  r_idx_q;
  logic [47:0] r_mac_q;
  logic [2:0]  r_reach_q;
  logic [2:0]  r_flags_q;
  logic [31:0] r_exp_q;

  logic       match;
  logic       is_router;
  logic [IDX_W-1:0] nx, pv, r;

  assign match = valid_q[ptr_q] && khi_q[ptr_q] == ahi_q && klo_q[ptr_q] == alo_q &&
                 ifn_q[ptr_q] == aif_q;
  assign is_router = (op_q == OP_ADD_ROUTER);
  assign r  = fidx_q;
  assign nx = next_q[fidx_q];
  assign pv = prev_q[fidx_q];

  assign stat_o.op        = op_q;
  assign stat_o.found     = found_q;
  assign stat_o.free_ok   = free_ok_q;
  assign stat_o.head_ok   = head_ok_q;
  assign stat_o.scan_last = (ptr_q == IDX_W'(ENTRY_COUNT - 1));

  // transaction latch and search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= '0;
      ahi_q     <= '0;
      alo_q     <= '0;
      aif_q     <= '0;
      amac_q    <= '0;
      aexp_q    <= '0;
      aha_q     <= 1'b0;
      ptr_q     <= '0;
      fidx_q    <= '0;
      free_q    <= '0;
      tail_q    <= '0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q      <= op_i;
        ahi_q     <= addr_high_i;
        alo_q     <= addr_low_i;
        aif_q     <= interface_num_i;
        amac_q    <= link_address_i;
        aexp_q    <= expiry_ticks_i;
        aha_q     <= home_agent_i;
        ptr_q     <= '0;
        found_q   <= 1'b0;
        free_ok_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        // keep the lowest matching slot and the lowest free slot
        if (!found_q && match) begin
          found_q <= 1'b1;
          fidx_q  <= ptr_q;
        end
        if (!free_ok_q && !valid_q[ptr_q]) begin
          free_ok_q <= 1'b1;
          free_q    <= ptr_q;
        end
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.read_tail) begin
        tail_q <= prev_q[head_q];
      end
    end
  end

  // slot storage and ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        valid_q[i] <= 1'b0;
        khi_q[i]   <= '0;
        klo_q[i]   <= '0;
        ifn_q[i]   <= '0;
        mac_q[i]   <= '0;
        reach_q[i] <= '0;
        flags_q[i] <= '0;
        exp_q[i]   <= '0;
        next_q[i]  <= '0;
        prev_q[i]  <= '0;
      end
      head_ok_q <= 1'b0;
      head_q    <= '0;
    end else begin
      if (cmd_i.clear_all) begin
        for (int i = 0; i < ENTRY_COUNT; i++) begin
          valid_q[i] <= 1'b0;
          khi_q[i]   <= '0;
          klo_q[i]   <= '0;
          ifn_q[i]   <= '0;
          mac_q[i]   <= '0;
          reach_q[i] <= '0;
          flags_q[i] <= '0;
          exp_q[i]   <= '0;
          next_q[i]  <= '0;
          prev_q[i]  <= '0;
        end
        head_ok_q <= 1'b0;
        head_q    <= '0;
      end
      if (cmd_i.scan && op_q == OP_INVAL_IF && valid_q[ptr_q] && ifn_q[ptr_q] == aif_q) begin
        reach_q[ptr_q] <= REACH_PROBE;
      end
      if (cmd_i.write_new) begin
        valid_q[free_q] <= 1'b1;
        khi_q[free_q]   <= ahi_q;
        klo_q[free_q]   <= alo_q;
        ifn_q[free_q]   <= aif_q;
        mac_q[free_q]   <= (op_q == OP_ADD) ? 48'd0 : amac_q;
        reach_q[free_q] <= (op_q == OP_ADD) ? REACH_INCOMPLETE : REACH_STALE;
        flags_q[free_q] <= {1'b0, is_router & aha_q, is_router};
        exp_q[free_q]   <= is_router ? aexp_q : 32'd0;
        next_q[free_q]  <= '0;
        prev_q[free_q]  <= '0;
      end
      if (cmd_i.link) begin
        flags_q[free_q][FLAG_RING] <= 1'b1;
        if (head_ok_q) begin
          // insert just before the head
          next_q[tail_q] <= free_q;
          prev_q[free_q] <= tail_q;
          next_q[free_q] <= head_q;
          prev_q[head_q] <= free_q;
        end else begin
          head_ok_q      <= 1'b1;
          head_q         <= free_q;
          next_q[free_q] <= free_q;
          prev_q[free_q] <= free_q;
        end
      end
      if (cmd_i.unlink) begin
        if (flags_q[r][FLAG_RING]) begin
          if (nx == r) begin
            head_ok_q <= 1'b0;
            head_q    <= '0;
          end else begin
            if (head_ok_q && head_q == r) begin
              head_q <= nx;
            end
            prev_q[nx] <= pv;
            next_q[pv] <= nx;
          end
        end
        valid_q[r] <= 1'b0;
        khi_q[r]   <= '0;
        klo_q[r]   <= '0;
        ifn_q[r]   <= '0;
        mac_q[r]   <= '0;
        reach_q[r] <= '0;
        flags_q[r] <= '0;
        exp_q[r]   <= '0;
        next_q[r]  <= '0;
        prev_q[r]  <= '0;
      end
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_status_q <= cmd_i.status;
      case (cmd_i.cap)
        CAP_FOUND: begin
          r_hit_q   <= 1'b1;
          r_idx_q   <= 4'(fidx_q);
          r_mac_q   <= mac_q[fidx_q];
          r_reach_q <= reach_q[fidx_q];
          r_flags_q <= flags_q[fidx_q];
          r_exp_q   <= exp_q[fidx_q];
        end
        CAP_NEW: begin
          r_hit_q   <= 1'b0;
          r_idx_q   <= 4'(free_q);
          r_mac_q   <= (op_q == OP_ADD) ? 48'd0 : amac_q;
          r_reach_q <= (op_q == OP_ADD) ? REACH_INCOMPLETE : REACH_STALE;
          r_flags_q <= {is_router, is_router & aha_q, is_router};
          r_exp_q   <= is_router ? aexp_q : 32'd0;
        end
        default: begin
          r_hit_q   <= 1'b0;
          r_idx_q   <= '0;
          r_mac_q   <= '0;
          r_reach_q <= '0;
          r_flags_q <= '0;
          r_exp_q   <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      status_o              <= r_status_q;
      hit_o                 <= r_hit_q;
      entry_index_o         <= r_idx_q;
      mac_out_o             <= r_mac_q;
      reach_state_o         <= r_reach_q;
      router_flag_o         <= r_flags_q[FLAG_ROUTER];
      home_agent_flag_o     <= r_flags_q[FLAG_HOME];
      default_router_flag_o <= r_flags_q[FLAG_RING];
      expiry_out_o          <= r_exp_q;
      ring_head_valid_o     <= head_ok_q;
      ring_head_index_o     <= head_ok_q ? 4'(head_q) : 4'd0;
    end
  end

endmodule

// ===== rtl/core/nct_ctrl.sv =====
// ----------------------------------------------------------------------------
// nct_ctrl: neighbor cache table controller
// Sequences scan, execute, ring update and publish for one transaction.
// ----------------------------------------------------------------------------
module nct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  nct_pkg::dp_stat_t  stat_i,
  output nct_pkg::cmd_t      cmd_o
);
  import nct_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_TAIL   = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_UNLINK = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.capture = 1'b1;
        cmd_o.cap     = CAP_NONE;
        cmd_o.status  = ST_OK;
        state_d       = S_FIN;
        case (stat_i.op)
          OP_LOOKUP: begin
            if (stat_i.found) begin
              cmd_o.cap = CAP_FOUND;
            end else begin
              cmd_o.status = ST_NOT_FOUND;
            end
          end
          OP_ADD, OP_ADD_MAC, OP_ADD_ROUTER: begin
            if (stat_i.found) begin
              cmd_o.cap    = CAP_FOUND;
              cmd_o.status = ST_DUP;
            end else if (!stat_i.free_ok) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.cap       = CAP_NEW;
              cmd_o.write_new = 1'b1;
              if (stat_i.op == OP_ADD_ROUTER) begin
                state_d = stat_i.head_ok ? S_TAIL : S_LINK;
              end
            end
          end
          OP_REMOVE: begin
            if (stat_i.found) begin
              // report the entry as it was, then unlink and clear it
              cmd_o.cap = CAP_FOUND;
              state_d   = S_UNLINK;
            end else begin
              cmd_o.status = ST_NOT_FOUND;
            end
          end
          OP_INVAL_ALL: begin
            cmd_o.clear_all = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_TAIL: begin
        cmd_o.read_tail = 1'b1;
        state_d         = S_LINK;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_FIN;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/neighbour_cache_table_top.sv =====
// ----------------------------------------------------------------------------
// neighbour_cache_table_top: neighbor cache table
// Bounded table of neighbors keyed by address and interface, with a
// default-router ring. One result transaction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries an operation and its key,
//   output channel out_valid_o / out_stall_i carries the status, the entry
//   reported and the ring head after the operation. A transaction moves at
//   a clock edge with valid high and stall low.
//   Every operation scans all ENTRY_COUNT slots, one slot per cycle, through
//   the scan pointer. A transaction then passes the execute step (for add
//   router also a ring link step, after a tail read on a non-empty ring; for
//   remove of a present key an unlink step) and the publish step; the next
//   transaction is accepted in the cycle after the result is loaded.
//   The output register holds a result while the receiver stalls; the next
//   transaction is already accepted and processed, and waits only for the
//   output register before publishing.
//   Reset clears every slot and empties the ring at once; the block takes
//   a transaction in the first cycle after reset.
// ----------------------------------------------------------------------------
module neighbour_cache_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  interface_num_i,
  input  logic [47:0] link_address_i,
  input  logic [31:0] expiry_ticks_i,
  input  logic        home_agent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        hit_o,
  output logic [3:0]  entry_index_o,
  output logic [47:0] mac_out_o,
  output logic [2:0]  reach_state_o,
  output logic        router_flag_o,
  output logic        home_agent_flag_o,
  output logic        default_router_flag_o,
  output logic [31:0] expiry_out_o,
  output logic        ring_head_valid_o,
  output logic [3:0]  ring_head_index_o
);
  import nct_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  nct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  nct_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .op_i                  (op_i),
    .addr_high_i           (addr_high_i),
    .addr_low_i            (addr_low_i),
    .interface_num_i       (interface_num_i),
    .link_address_i        (link_address_i),
    .expiry_ticks_i        (expiry_ticks_i),
    .home_agent_i          (home_agent_i),
    .status_o              (status_o),
    .hit_o                 (hit_o),
    .entry_index_o         (entry_index_o),
    .mac_out_o             (mac_out_o),
    .reach_state_o         (reach_state_o),
    .router_flag_o         (router_flag_o),
    .home_agent_flag_o     (home_agent_flag_o),
    .default_router_flag_o (default_router_flag_o),
    .expiry_out_o          (expiry_out_o),
    .ring_head_valid_o     (ring_head_valid_o),
    .ring_head_index_o     (ring_head_index_o)
  );

endmodule
